// ----- design/edrs_pkg.sv -----
// Shared constants and types of the elevator disk request scheduler.
`default_nettype none

package edrs_pkg;

    localparam int TABLE_ENTRIES  = 16;
    localparam int CYLINDER_COUNT = 200;
    localparam int IDX_W          = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [7:0]       CYL_MAX  = 8'(CYLINDER_COUNT - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] ST_ACCEPTED   = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_DISPATCHED = 2'd2;
    localparam logic [1:0] ST_NONE       = 2'd3;

    localparam logic KIND_REGISTER = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    typedef struct packed {
        logic [7:0] tag;
        logic [7:0] cyl;
        logic [4:0] track;
        logic [2:0] rec;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_entry;
        logic             clr_en;
        logic [IDX_W-1:0] clr_idx;
    } table_wr_t;

endpackage

`default_nettype wire

// ----- design/edrs_table.sv -----
// Request table: per-slot valid flags, stored entries and the free-slot finder.
`default_nettype none

module edrs_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire edrs_pkg::table_wr_t           wr,
    input  wire logic [edrs_pkg::IDX_W-1:0]    rd_idx,
    output edrs_pkg::entry_t                   rd_entry,
    output logic                               rd_valid,
    output logic                               any_valid,
    output logic                               full,
    output logic [edrs_pkg::IDX_W-1:0]         free_idx
);
    import edrs_pkg::*;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    entry_t                   entry_reg [TABLE_ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (wr.wr_en)
            begin
                valid_reg[wr.wr_idx] <= 1'b1;
            end
            if (wr.clr_en)
            begin
                valid_reg[wr.clr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            entry_reg[wr.wr_idx] <= wr.wr_entry;
        end
    end

    assign rd_entry  = entry_reg[rd_idx];
    assign rd_valid  = valid_reg[rd_idx];
    assign any_valid = |valid_reg;
    assign full      = &valid_reg;

    // Lowest free slot wins, so scan from the top down.
    always_comb
    begin
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/edrs_cmp.sv -----
// Shared compare unit: decides whether the scanned slot beats the best so far.
`default_nettype none

module edrs_cmp (
    input  wire logic       slot_valid,
    input  wire logic [7:0] cyl,
    input  wire logic [7:0] head,
    input  wire logic [7:0] best_cyl,
    input  wire logic       have_best,
    input  wire logic       want_low,
    input  wire logic       use_bound,
    output logic            take
);
    import edrs_pkg::*;

    logic excluded;
    logic better;

    always_comb
    begin
        excluded = use_bound && (want_low ? (cyl < head) : (cyl > head));
        better   = want_low ? (cyl < best_cyl) : (cyl > best_cyl);
        take     = slot_valid && !excluded && (!have_best || better);
    end

endmodule

`default_nettype wire

// ----- design/elevator_disk_request_scheduler.sv -----
// Top level of the elevator disk request scheduler: sequencer, head state and output register.
`default_nettype none

// A register beat is decided at once: the lowest free slot is found and the request is stored
// or dropped, and the registered result enters the output register from the done state.
// A dispatch beat walks the table one slot per cycle through a single compare unit. It makes
// one pass over all TABLE_ENTRIES slots when a request lies ahead of the head in the current
// direction, and otherwise a second pass in the opposite direction. A fetch state then reads the
// chosen entry and clears its slot, and the done state hands the result over. An empty table
// answers a dispatch from the done state without a scan. Loading waits while the output
// register still holds a result that has not been taken. The input side is ready only while
// the sequencer is idle, which is again the cycle after loading. The block therefore takes
// no new item before the reply to the last one has been loaded.
module elevator_disk_request_scheduler (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       kind,
    input  wire logic [7:0] requester_tag,
    input  wire logic [7:0] cylinder,
    input  wire logic [4:0] track,
    input  wire logic [2:0] record,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      status,
    output logic [7:0]      out_tag,
    output logic [7:0]      out_cylinder,
    output logic [4:0]      out_track,
    output logic [2:0]      out_record,
    output logic            going_down
);
    import edrs_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [7:0]       head_reg, head_next;
    logic             sweep_reg, sweep_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [7:0]       best_cyl_reg, best_cyl_next;
    logic             found_reg, found_next;
    logic             want_low_reg, want_low_next;
    logic             bound_reg, bound_next;

    logic [1:0]       res_status_reg, res_status_next;
    entry_t           res_entry_reg, res_entry_next;
    logic             res_down_reg, res_down_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg;
    entry_t           out_entry_reg;
    logic             out_down_reg;

    table_wr_t        wr;
    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_entry;
    logic             rd_valid;
    logic             any_valid;
    logic             full;
    logic [IDX_W-1:0] free_idx;
    logic             take;
    logic             in_fire;
    logic             out_load;

    edrs_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .rd_idx    (rd_idx),
        .rd_entry  (rd_entry),
        .rd_valid  (rd_valid),
        .any_valid (any_valid),
        .full      (full),
        .free_idx  (free_idx)
    );

    edrs_cmp u_cmp (
        .slot_valid (rd_valid),
        .cyl        (rd_entry.cyl),
        .head       (head_reg),
        .best_cyl   (best_cyl_reg),
        .have_best  (found_reg),
        .want_low   (want_low_reg),
        .use_bound  (bound_reg),
        .take       (take)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign rd_idx   = (state_reg == S_FETCH) ? best_idx_reg : idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        sweep_next      = sweep_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        best_cyl_next   = best_cyl_reg;
        found_next      = found_reg;
        want_low_next   = want_low_reg;
        bound_next      = bound_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_down_next   = res_down_reg;

        wr.wr_en          = 1'b0;
        wr.wr_idx         = free_idx;
        wr.wr_entry.tag   = requester_tag;
        wr.wr_entry.cyl   = (cylinder > CYL_MAX) ? CYL_MAX : cylinder;
        wr.wr_entry.track = track;
        wr.wr_entry.rec   = record;
        wr.clr_en         = 1'b0;
        wr.clr_idx        = best_idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_entry_next = '0;
                    res_down_next  = sweep_reg;
                    if (kind == KIND_REGISTER)
                    begin
                        if (full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr.wr_en        = 1'b1;
                            res_status_next = ST_ACCEPTED;
                        end
                        state_next = S_DONE;
                    end
                    else if (!any_valid)
                    begin
                        res_status_next = ST_NONE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next      = '0;
                        found_next    = 1'b0;
                        want_low_next = !sweep_reg;
                        bound_next    = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (take)
                begin
                    best_idx_next = idx_reg;
                    best_cyl_next = rd_entry.cyl;
                    found_next    = 1'b1;
                end
                if (idx_reg == IDX_LAST)
                begin
                    if (found_reg || take)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        // Nothing ahead of the head: turn around and take the far extreme.
                        idx_next      = '0;
                        found_next    = 1'b0;
                        want_low_next = !want_low_reg;
                        bound_next    = 1'b0;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FETCH:
            begin
                wr.clr_en       = 1'b1;
                res_entry_next  = rd_entry;
                res_status_next = ST_DISPATCHED;
                res_down_next   = !want_low_reg;
                sweep_next      = !want_low_reg;
                head_next       = rd_entry.cyl;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            sweep_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        best_idx_reg   <= best_idx_next;
        best_cyl_reg   <= best_cyl_next;
        found_reg      <= found_next;
        want_low_reg   <= want_low_next;
        bound_reg      <= bound_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        res_down_reg   <= res_down_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
            out_down_reg   <= res_down_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_tag      = out_entry_reg.tag;
    assign out_cylinder = out_entry_reg.cyl;
    assign out_track    = out_entry_reg.track;
    assign out_record   = out_entry_reg.rec;
    assign going_down   = out_down_reg;

endmodule

`default_nettype wire

// ----- tb/sv/disk_sched_checker.sv -----
// Checker for the elevator disk request scheduler: predicts each reply and compares it.
`default_nettype none

module disk_sched_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic       kind,
    input  wire logic [7:0] requester_tag,
    input  wire logic [7:0] cylinder,
    input  wire logic [4:0] track,
    input  wire logic [2:0] record,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [1:0] status,
    input  wire logic [7:0] out_tag,
    input  wire logic [7:0] out_cylinder,
    input  wire logic [4:0] out_track,
    input  wire logic [2:0] out_record,
    input  wire logic       going_down,
    output int              mismatches,
    output int              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import edrs_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        entry_t     picked;
        logic       down;
    } sched_reply_t;

    logic          slot_busy [TABLE_ENTRIES];
    entry_t        slot_entry [TABLE_ENTRIES];
    logic [7:0]    head_cyl;
    logic          sweep_down;
    sched_reply_t  awaited_replies [$];
    int            fail_count = 0;

    assign mismatches  = fail_count;
    assign outstanding = awaited_replies.size();

    // Best busy slot: lowest or highest cylinder, optionally limited by the head.
    function automatic int nearest_slot(bit want_low, bit bounded);
        int         best;
        logic [7:0] best_cyl;
        logic [7:0] c;
        best = -1;
        best_cyl = '0;
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
            if (!slot_busy[s])
                continue;
            c = slot_entry[s].cyl;
            if (bounded && want_low && c < head_cyl)
                continue;
            if (bounded && !want_low && c > head_cyl)
                continue;
            if (best < 0 || (want_low ? (c < best_cyl) : (c > best_cyl))) begin
                best = s;
                best_cyl = c;
            end
        end
        return best;
    endfunction

    function automatic sched_reply_t elevator_step(logic k, entry_t req);
        sched_reply_t r;
        int           slot;
        r = '0;
        slot = -1;
        if (k == KIND_REGISTER) begin
            for (int s = 0; s < TABLE_ENTRIES; s++) begin
                if (!slot_busy[s]) begin
                    slot = s;
                    break;
                end
            end
            if (slot < 0) begin
                r.status = ST_FULL;
            end else begin
                if (req.cyl > CYL_MAX)
                    req.cyl = CYL_MAX;
                slot_busy[slot] = 1'b1;
                slot_entry[slot] = req;
                r.status = ST_ACCEPTED;
            end
        end else begin
            // Keep sweeping the current way; turn around only when nothing lies ahead.
            if (!sweep_down) begin
                slot = nearest_slot(1'b1, 1'b1);
                if (slot < 0) begin
                    slot = nearest_slot(1'b0, 1'b0);
                    if (slot >= 0)
                        sweep_down = 1'b1;
                end
            end else begin
                slot = nearest_slot(1'b0, 1'b1);
                if (slot < 0) begin
                    slot = nearest_slot(1'b1, 1'b0);
                    if (slot >= 0)
                        sweep_down = 1'b0;
                end
            end
            if (slot < 0) begin
                r.status = ST_NONE;
            end else begin
                r.status = ST_DISPATCHED;
                r.picked = slot_entry[slot];
                head_cyl = slot_entry[slot].cyl;
                slot_busy[slot] = 1'b0;
            end
        end
        r.down = sweep_down;
        return r;
    endfunction

    function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        sched_reply_t req_reply;
        sched_reply_t want;
        if (!rst_n) begin
            for (int s = 0; s < TABLE_ENTRIES; s++)
                slot_busy[s] = 1'b0;
            head_cyl = '0;
            sweep_down = 1'b0;
            awaited_replies.delete();
        end else begin
            if (in_valid && in_ready) begin
                req_reply = elevator_step(kind, '{tag: requester_tag, cyl: cylinder,
                                                  track: track, rec: record});
                awaited_replies.push_back(req_reply);
            end
            if (out_valid && out_ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("reply beat with no request waiting for it");
                    fail_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    compare_field("status", 8'(want.status), 8'(status));
                    compare_field("out_tag", want.picked.tag, out_tag);
                    compare_field("out_cylinder", want.picked.cyl, out_cylinder);
                    compare_field("out_track", 8'(want.picked.track), 8'(out_track));
                    compare_field("out_record", 8'(want.picked.rec), 8'(out_record));
                    compare_field("going_down", 8'(want.down), 8'(going_down));
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_elevator_disk_request_scheduler.sv -----
// Testbench top for the elevator disk request scheduler: stimulus, reply stalls and verdict.
`default_nettype none

module tb_elevator_disk_request_scheduler;
    timeunit 1ns;
    timeprecision 1ps;
    import edrs_pkg::*;

    localparam int RANDOM_ITEMS = 1280;
    localparam int HOLD_CYCLES  = 400;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       kind = KIND_REGISTER;
    logic [7:0] requester_tag = '0;
    logic [7:0] cylinder = '0;
    logic [4:0] track = '0;
    logic [2:0] record = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] status;
    logic [7:0] out_tag;
    logic [7:0] out_cylinder;
    logic [4:0] out_track;
    logic [2:0] out_record;
    logic       going_down;
    int         mismatches;
    int         outstanding;

    bit         long_hold_wanted = 1'b0;

    elevator_disk_request_scheduler dut (.*);

    disk_sched_checker checker_i (.*);

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Offer one beat and hold it until the block takes it.
    task automatic offer_beat(input logic k, input logic [7:0] tag, input logic [7:0] cyl,
                              input logic [4:0] trk, input logic [2:0] rec);
        in_valid      <= 1'b1;
        kind          <= k;
        requester_tag <= tag;
        cylinder      <= cyl;
        track         <= trk;
        record        <= rec;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Cylinders lean on a few shared values so that ties and exact head hits show up.
    function automatic logic [7:0] pick_cylinder();
        logic [7:0] shared [4] = '{8'd0, 8'd50, 8'd100, 8'd199};
        case ($urandom_range(0, 9))
            0:       return 8'($urandom_range(200, 255));
            1, 2:    return shared[$urandom_range(0, 3)];
            default: return 8'($urandom_range(0, 199));
        endcase
    endfunction

    // Reply side: changing stall styles, plus one long hold-off so the block backs up.
    initial begin
        int pattern;
        int beat_no;
        int hold_count;
        pattern = 0;
        beat_no = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (long_hold_wanted) begin
                long_hold_wanted = 1'b0;
                out_ready <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(posedge clk);
                    hold_count++;
                end
            end else begin
                beat_no++;
                case (pattern)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ((beat_no % 7) < 3);
                    default: out_ready <= ($urandom_range(0, 9) == 0);
                endcase
                if (beat_no % 97 == 0)
                    pattern = $urandom_range(0, 3);
            end
        end
    end

    initial begin
        int burst_left;
        int gap;
        int mix;
        logic k;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, saturation, ties, turning at both ends.
        offer_beat(KIND_DISPATCH, 8'hFF, 8'hFF, 5'h1F, 3'h7);
        offer_beat(KIND_REGISTER, 8'h00, 8'd0, 5'd0, 3'd0);
        offer_beat(KIND_REGISTER, 8'hFF, 8'd255, 5'd31, 3'd7);
        offer_beat(KIND_REGISTER, 8'h12, 8'd199, 5'd19, 3'd3);
        offer_beat(KIND_REGISTER, 8'h34, 8'd200, 5'd20, 3'd5);
        offer_beat(KIND_REGISTER, 8'h56, 8'd100, 5'd7, 3'd1);
        offer_beat(KIND_REGISTER, 8'h78, 8'd100, 5'd8, 3'd2);
        offer_beat(KIND_DISPATCH, 8'h00, 8'd0, 5'd0, 3'd0);
        offer_beat(KIND_DISPATCH, 8'hAA, 8'h55, 5'h15, 3'h5);
        offer_beat(KIND_DISPATCH, 8'h00, 8'd0, 5'd0, 3'd0);
        offer_beat(KIND_REGISTER, 8'h9A, 8'd50, 5'd10, 3'd4);
        offer_beat(KIND_DISPATCH, 8'h00, 8'd0, 5'd0, 3'd0);
        offer_beat(KIND_DISPATCH, 8'h00, 8'd0, 5'd0, 3'd0);
        offer_beat(KIND_DISPATCH, 8'h00, 8'd0, 5'd0, 3'd0);
        offer_beat(KIND_DISPATCH, 8'h00, 8'd0, 5'd0, 3'd0);
        offer_beat(KIND_DISPATCH, 8'h00, 8'd0, 5'd0, 3'd0);
        offer_beat(KIND_REGISTER, 8'hBC, 8'd10, 5'd1, 3'd6);
        offer_beat(KIND_DISPATCH, 8'h00, 8'd0, 5'd0, 3'd0);
        offer_beat(KIND_REGISTER, 8'hDE, 8'd150, 5'd2, 3'd0);
        offer_beat(KIND_DISPATCH, 8'h00, 8'd0, 5'd0, 3'd0);
        offer_beat(KIND_DISPATCH, 8'h00, 8'd0, 5'd0, 3'd0);

        // Random: phases that fill the table past full, balance, or drain it empty.
        long_hold_wanted = 1'b1;
        burst_left = $urandom_range(1, 40);
        mix = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 60 == 0)
                mix = $urandom_range(0, 2);
            case (mix)
                0:       k = ($urandom_range(0, 99) < 85) ? KIND_REGISTER : KIND_DISPATCH;
                1:       k = ($urandom_range(0, 99) < 50) ? KIND_REGISTER : KIND_DISPATCH;
                default: k = ($urandom_range(0, 99) < 20) ? KIND_REGISTER : KIND_DISPATCH;
            endcase
            offer_beat(k, 8'($urandom_range(0, 255)), pick_cylinder(),
                       5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)));
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;

        // Let the checker record the last accepted beat before looking at the count.
        @(posedge clk);
        wait (outstanding == 0);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
